@@ rtl/cpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

  localparam int unsigned VTX_N  = 1024;
  localparam int unsigned VTX_W  = $clog2(VTX_N);
  localparam int unsigned EDG_N  = 2048;
  localparam int unsigned EDG_W  = $clog2(EDG_N);
  localparam int unsigned ECNT_W = EDG_W + 1;
  localparam int unsigned CNT_W  = VTX_W + 1;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned TIME_W = 26;
  localparam int unsigned DEG_W  = 12;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STS_W  = 2;

  localparam logic [TIME_W-1:0] TIME_ALL = {TIME_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_ANALYZE = 3'd1,
    CMD_RD_EDGE = 3'd2,
    CMD_RD_VTX  = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_CYCLE = 2'd2,
    STS_RANGE = 2'd3
  } sts_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR,
    ST_IND_RD, ST_IND_EDGE, ST_IND_UPD,
    ST_SEED_RD, ST_SEED_CHK,
    ST_K_TOP, ST_K_V, ST_K_RD, ST_K_EDGE, ST_K_UPD,
    ST_E_TOP, ST_E_V, ST_E_EV, ST_E_RD, ST_E_EDGE, ST_E_UPD,
    ST_L_INIT, ST_L_TOP, ST_L_V, ST_L_EV, ST_L_RD, ST_L_EDGE, ST_L_UPD,
    ST_FIN, ST_RE_EDGE, ST_RE_T, ST_RE_H, ST_RV, ST_OUT
  } state_e;

  typedef struct packed {
    logic [VTX_W-1:0] tail;
    logic [VTX_W-1:0] head;
    logic [WGT_W-1:0] wgt;
  } edg_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                               input logic [WGT_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + (TIME_W+1)'(b);
    return s[TIME_W] ? TIME_ALL : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/cpa_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cpa_in_if;
  import cpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VTX_W-1:0]   from_vertex;
  logic [VTX_W-1:0]   to_vertex;
  logic [WGT_W-1:0]   weight;
  logic [EDG_W-1:0]   item_index;
  modport source(output valid, cmd, from_vertex, to_vertex, weight, item_index,
                 input ready);
  modport sink(input valid, cmd, from_vertex, to_vertex, weight, item_index,
               output ready);
endinterface

interface cpa_out_if;
  import cpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STS_W-1:0]   status;
  logic [TIME_W-1:0]  project_length;
  logic [TIME_W-1:0]  early_time;
  logic [TIME_W-1:0]  late_time;
  logic               is_critical;
  logic [ECNT_W-1:0]  edge_total;
  modport source(output valid, status, project_length, early_time, late_time,
                 is_critical, edge_total, input ready);
  modport sink(input valid, status, project_length, early_time, late_time,
               is_critical, edge_total, output ready);
endinterface

`default_nettype wire

@@ rtl/critical_path_analyzer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Critical path analyser for an activity-on-edge network. Edges go into a
// 2048-word edge store by the load command; an analyse command clears the
// vertex times, counts in-degrees, orders the vertices 0..vertex_top by Kahn's
// method, then makes a forward pass for earliest times and a backward pass for
// latest times, and reports the project length. Every word in gives one word
// out. A clearing pass (one vertex entry a cycle) runs after reset, on clear
// and at the start of each analysis; no word is taken during it. Analysis
// then counts in-degrees in one scan of the edge store, seeds the order
// queue from the vertices, and makes three scans of the edge store for each
// ordered vertex.
module critical_path_analyzer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cpa_pkg::VTX_W-1:0] cfg_wdata_i,
  cpa_in_if.sink                    in_i,
  cpa_out_if.source                 out_o
);
  import cpa_pkg::*;

  // edge store and vertex stores
  edg_t              edg_mem [EDG_N];
  logic [DEG_W-1:0]  deg_mem [VTX_N];
  logic [TIME_W-1:0] ear_mem [VTX_N];
  logic [TIME_W-1:0] rem_mem [VTX_N];
  logic [TIME_W-1:0] lat_mem [VTX_N];
  logic [VTX_W-1:0]  topo_mem [VTX_N];

  edg_t              edg_rd_q;
  logic [DEG_W-1:0]  deg_rd_q;
  logic [TIME_W-1:0] ear_rd_q, rem_rd_q, lat_rd_q;
  logic [VTX_W-1:0]  topo_rd_q;

  logic              edg_we;
  logic [EDG_W-1:0]  edg_wa, edg_ra;
  edg_t              edg_wd;
  logic [VTX_W-1:0]  vwa, vra, twa, tra, twd;
  logic              deg_we, ear_we, rem_we, lat_we, topo_we;
  logic [DEG_W-1:0]  deg_wd;
  logic [TIME_W-1:0] ear_wd, rem_wd, lat_wd;

  // control
  state_e            state_q, state_d, after_q, after_d;
  logic [CNT_W-1:0]  i_q, i_d, qt_q, qt_d;
  logic [ECNT_W-1:0] e_q, e_d, ec_q, ec_d;
  logic [TIME_W-1:0] proj_q, proj_d;
  logic [VTX_W-1:0]  top_q, top_d;
  logic              ov_q, ov_d;

  // datapath
  logic [VTX_W-1:0]  v_q, v_d, h_q, h_d;
  logic [WGT_W-1:0]  w_q, w_d;
  logic [TIME_W-1:0] ev_q, ev_d, mx_q, mx_d;
  logic [STS_W-1:0]  rs_q, rs_d;
  logic [TIME_W-1:0] re_q, re_d, rl_q, rl_d;
  logic              rc_q, rc_d;
  logic [STS_W-1:0]  os_q, os_d;
  logic [TIME_W-1:0] op_q, op_d, oe_q, oe_d, ol_q, ol_d;
  logic              oc_q, oc_d;
  logic [ECNT_W-1:0] on_q, on_d;

  logic              acc, used;
  logic [TIME_W-1:0] sum, hi, lt;

  assign acc   = in_i.valid && in_i.ready;
  assign used  = (edg_rd_q.tail <= top_q) && (edg_rd_q.head <= top_q);
  assign sum   = sat_add(ev_q, w_q);

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.status         = os_q;
  assign out_o.project_length = op_q;
  assign out_o.early_time     = oe_q;
  assign out_o.late_time      = ol_q;
  assign out_o.is_critical    = oc_q;
  assign out_o.edge_total     = on_q;

  always_comb begin
    state_d = state_q;  after_d = after_q;
    i_d = i_q;  qt_d = qt_q;  e_d = e_q;  ec_d = ec_q;
    proj_d = proj_q;  top_d = top_q;  ov_d = ov_q && !out_o.ready;
    v_d = v_q;  h_d = h_q;  w_d = w_q;  ev_d = ev_q;  mx_d = mx_q;
    rs_d = rs_q;  re_d = re_q;  rl_d = rl_q;  rc_d = rc_q;
    os_d = os_q;  op_d = op_q;  oe_d = oe_q;  ol_d = ol_q;  oc_d = oc_q;  on_d = on_q;
    edg_we = 1'b0;  edg_wa = ec_q[EDG_W-1:0];  edg_ra = e_q[EDG_W-1:0];
    edg_wd = '{tail: in_i.from_vertex, head: in_i.to_vertex, wgt: in_i.weight};
    vwa = h_q;  vra = h_q;  twa = qt_q[VTX_W-1:0];  tra = i_q[VTX_W-1:0];  twd = h_q;
    deg_we = 1'b0;  ear_we = 1'b0;  rem_we = 1'b0;  lat_we = 1'b0;  topo_we = 1'b0;
    deg_wd = '0;  ear_wd = '0;  rem_wd = '0;  lat_wd = TIME_ALL;
    hi = (sum > ear_rd_q) ? sum : ear_rd_q;
    lt = '0;

    if (cfg_we_i) top_d = cfg_wdata_i;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          rs_d = STS_OK;  re_d = '0;  rl_d = '0;  rc_d = 1'b0;
          state_d = ST_OUT;
          case (in_i.cmd)
            CMD_LOAD: begin
              if (ec_q < ECNT_W'(EDG_N)) begin
                edg_we = 1'b1;
                ec_d   = ec_q + 1'b1;
              end else begin
                rs_d = STS_FULL;
              end
            end
            CMD_ANALYZE: begin
              i_d = '0;  e_d = '0;  qt_d = '0;  mx_d = '0;
              after_d = ST_IND_RD;  state_d = ST_CLR;
            end
            CMD_RD_EDGE: begin
              if ({1'b0, in_i.item_index} >= ec_q) begin
                rs_d = STS_RANGE;
              end else begin
                edg_ra  = in_i.item_index;
                state_d = ST_RE_EDGE;
              end
            end
            CMD_RD_VTX: begin
              if (in_i.item_index > {1'b0, top_q}) begin
                rs_d = STS_RANGE;
              end else begin
                vra     = in_i.item_index[VTX_W-1:0];
                state_d = ST_RV;
              end
            end
            CMD_CLEAR: begin
              ec_d = '0;  proj_d = '0;  i_d = '0;
              after_d = ST_OUT;  state_d = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        vwa = i_q[VTX_W-1:0];
        deg_we = 1'b1;  ear_we = 1'b1;  rem_we = 1'b1;  lat_we = 1'b1;
        i_d = i_q + 1'b1;
        if (i_q == CNT_W'(VTX_N - 1)) state_d = after_q;
      end
      // in-degree count
      ST_IND_RD: begin
        if (e_q >= ec_q) begin
          i_d = '0;  state_d = ST_SEED_RD;
        end else begin
          state_d = ST_IND_EDGE;
        end
      end
      ST_IND_EDGE: begin
        if (used) begin
          h_d = edg_rd_q.head;  vra = edg_rd_q.head;  state_d = ST_IND_UPD;
        end else begin
          e_d = e_q + 1'b1;  state_d = ST_IND_RD;
        end
      end
      ST_IND_UPD: begin
        deg_we = 1'b1;  deg_wd = deg_rd_q + 1'b1;
        e_d = e_q + 1'b1;  state_d = ST_IND_RD;
      end
      // seed the queue with zero in-degree vertices
      ST_SEED_RD: begin
        if (i_q > {1'b0, top_q}) begin
          i_d = '0;  state_d = ST_K_TOP;
        end else begin
          vra = i_q[VTX_W-1:0];  state_d = ST_SEED_CHK;
        end
      end
      ST_SEED_CHK: begin
        if (deg_rd_q == '0) begin
          topo_we = 1'b1;  twd = i_q[VTX_W-1:0];  qt_d = qt_q + 1'b1;
        end
        i_d = i_q + 1'b1;  state_d = ST_SEED_RD;
      end
      // Kahn ordering, i is the queue head
      ST_K_TOP: begin
        if (i_q >= qt_q) begin
          i_d = '0;  mx_d = '0;  state_d = ST_E_TOP;
        end else begin
          state_d = ST_K_V;
        end
      end
      ST_K_V: begin
        v_d = topo_rd_q;  i_d = i_q + 1'b1;  e_d = '0;  state_d = ST_K_RD;
      end
      ST_K_RD: state_d = (e_q >= ec_q) ? ST_K_TOP : ST_K_EDGE;
      ST_K_EDGE: begin
        if (used && edg_rd_q.tail == v_q) begin
          h_d = edg_rd_q.head;  vra = edg_rd_q.head;  state_d = ST_K_UPD;
        end else begin
          e_d = e_q + 1'b1;  state_d = ST_K_RD;
        end
      end
      ST_K_UPD: begin
        if (deg_rd_q != '0) begin
          deg_we = 1'b1;  deg_wd = deg_rd_q - 1'b1;
          if (deg_rd_q == DEG_W'(1)) begin
            topo_we = 1'b1;  qt_d = qt_q + 1'b1;
          end
        end
        e_d = e_q + 1'b1;  state_d = ST_K_RD;
      end
      // forward pass
      ST_E_TOP: state_d = (i_q >= qt_q) ? ST_L_INIT : ST_E_V;
      ST_E_V: begin
        v_d = topo_rd_q;  vra = topo_rd_q;  state_d = ST_E_EV;
      end
      ST_E_EV: begin
        ev_d = ear_rd_q;  i_d = i_q + 1'b1;  e_d = '0;  state_d = ST_E_RD;
      end
      ST_E_RD: state_d = (e_q >= ec_q) ? ST_E_TOP : ST_E_EDGE;
      ST_E_EDGE: begin
        if (used && edg_rd_q.tail == v_q) begin
          h_d = edg_rd_q.head;  w_d = edg_rd_q.wgt;  vra = edg_rd_q.head;
          state_d = ST_E_UPD;
        end else begin
          e_d = e_q + 1'b1;  state_d = ST_E_RD;
        end
      end
      ST_E_UPD: begin
        if (sum > ear_rd_q) begin
          ear_we = 1'b1;  ear_wd = sum;
        end
        if (hi > mx_q) mx_d = hi;
        e_d = e_q + 1'b1;  state_d = ST_E_RD;
      end
      // backward pass, sink starts at the project length
      ST_L_INIT: begin
        vwa = top_q;  lat_we = 1'b1;  lat_wd = mx_q;
        i_d = qt_q;  state_d = ST_L_TOP;
      end
      ST_L_TOP: begin
        tra = VTX_W'(i_q - 1'b1);
        state_d = (i_q == '0) ? ST_FIN : ST_L_V;
      end
      ST_L_V: begin
        v_d = topo_rd_q;  vra = topo_rd_q;  state_d = ST_L_EV;
      end
      ST_L_EV: begin
        ev_d = rem_rd_q;  i_d = i_q - 1'b1;  e_d = '0;  state_d = ST_L_RD;
      end
      ST_L_RD: state_d = (e_q >= ec_q) ? ST_L_TOP : ST_L_EDGE;
      ST_L_EDGE: begin
        if (used && edg_rd_q.head == v_q) begin
          h_d = edg_rd_q.tail;  w_d = edg_rd_q.wgt;  vra = edg_rd_q.tail;
          state_d = ST_L_UPD;
        end else begin
          e_d = e_q + 1'b1;  state_d = ST_L_RD;
        end
      end
      ST_L_UPD: begin
        hi = (sum > rem_rd_q) ? sum : rem_rd_q;
        if (sum > rem_rd_q) begin
          rem_we = 1'b1;  rem_wd = sum;
        end
        lt = (mx_q >= hi) ? mx_q - hi : '0;
        if (lt < lat_rd_q) begin
          lat_we = 1'b1;  lat_wd = lt;
        end
        e_d = e_q + 1'b1;  state_d = ST_L_RD;
      end
      ST_FIN: begin
        proj_d = mx_q;
        rs_d = (qt_q == {1'b0, top_q} + CNT_W'(1)) ? STS_OK : STS_CYCLE;
        state_d = ST_OUT;
      end
      // edge read: tail time, then head time
      ST_RE_EDGE: begin
        vra = edg_rd_q.tail;  h_d = edg_rd_q.head;  w_d = edg_rd_q.wgt;
        rc_d = used;  state_d = ST_RE_T;
      end
      ST_RE_T: begin
        re_d = ear_rd_q;  state_d = ST_RE_H;
      end
      ST_RE_H: begin
        rl_d = lat_rd_q;
        rc_d = rc_q && (lat_rd_q != TIME_ALL) && (lat_rd_q >= TIME_W'(w_q)) &&
               (re_q == lat_rd_q - TIME_W'(w_q));
        state_d = ST_OUT;
      end
      ST_RV: begin
        re_d = ear_rd_q;  rl_d = lat_rd_q;  state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          os_d = rs_q;  op_d = proj_q;  oe_d = re_q;  ol_d = rl_q;
          oc_d = rc_q;  on_d = ec_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      after_q <= ST_IDLE;
      i_q     <= '0;
      qt_q    <= '0;
      e_q     <= '0;
      ec_q    <= '0;
      proj_q  <= '0;
      top_q   <= VTX_W'(VTX_N - 1);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      i_q     <= i_d;
      qt_q    <= qt_d;
      e_q     <= e_d;
      ec_q    <= ec_d;
      proj_q  <= proj_d;
      top_q   <= top_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;  h_q <= h_d;  w_q <= w_d;  ev_q <= ev_d;  mx_q <= mx_d;
    rs_q <= rs_d;  re_q <= re_d;  rl_q <= rl_d;  rc_q <= rc_d;
    os_q <= os_d;  op_q <= op_d;  oe_q <= oe_d;  ol_q <= ol_d;  oc_q <= oc_d;
    on_q <= on_d;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (edg_we) edg_mem[edg_wa] <= edg_wd;
    edg_rd_q <= edg_mem[edg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[vwa] <= deg_wd;
    deg_rd_q <= deg_mem[vra];
  end

  always_ff @(posedge clk_i) begin
    if (ear_we) ear_mem[vwa] <= ear_wd;
    ear_rd_q <= ear_mem[vra];
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) rem_mem[vwa] <= rem_wd;
    rem_rd_q <= rem_mem[vra];
  end

  always_ff @(posedge clk_i) begin
    if (lat_we) lat_mem[vwa] <= lat_wd;
    lat_rd_q <= lat_mem[vra];
  end

  always_ff @(posedge clk_i) begin
    if (topo_we) topo_mem[twa] <= twd;
    topo_rd_q <= topo_mem[tra];
  end

  // checks
  a_ec_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= ECNT_W'(EDG_N)) else $error("edge count beyond store");

  a_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K_TOP) |-> (qt_q <= CNT_W'(VTX_N)))
    else $error("order queue overrun");

  a_analyse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.cmd == CMD_ANALYZE) |=> (state_q == ST_CLR))
    else $error("analysis did not start with a clearing pass");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!ov_q || out_o.ready)) |=> (ov_q && state_q == ST_IDLE))
    else $error("result word not presented");

endmodule

`default_nettype wire
